// ===== hw/rtl/swrm_pkg.sv =====
`timescale 1ns / 1ps

package swrm_pkg;

	// field widths
	localparam int VAL_W     = 32;
	localparam int CNT_OUT_W = 7;
	localparam int STATUS_W  = 2;

	// default stack depth
	localparam int DEPTH_DEF = 64;

	// command codes
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK        = 2'd0,
		STATUS_POP_EMPTY = 2'd1,
		STATUS_PUSH_FULL = 2'd2
	} status_t;

	// controller to datapath commands
	typedef struct packed {
		logic load_in;
		logic exec;
		logic load_rd;
		logic emit;
	} ctrl_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic need_read;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== hw/rtl/swrm_in_if.sv =====
`timescale 1ns / 1ps

interface swrm_in_if;
	import swrm_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    command;
	logic signed [VAL_W-1:0] push_value;

	modport source (output valid, output command, output push_value, input ready);
	modport sink   (input valid, input command, input push_value, output ready);
endinterface

// ===== hw/rtl/swrm_out_if.sv =====
`timescale 1ns / 1ps

interface swrm_out_if;
	import swrm_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] top_value;
	logic signed [VAL_W-1:0] min_value;
	logic [CNT_OUT_W-1:0]    item_count;
	logic                    is_empty;
	logic [STATUS_W-1:0]     status;

	modport source (output valid, output top_value, output min_value, output item_count,
		output is_empty, output status, input ready);
	modport sink   (input valid, input top_value, input min_value, input item_count,
		input is_empty, input status, output ready);
endinterface

// ===== hw/rtl/swrm_ram.sv =====
`timescale 1ns / 1ps

module swrm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== hw/rtl/swrm_ctrl.sv =====
`timescale 1ns / 1ps

module swrm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  swrm_pkg::dp_stat_t   stat,
	output swrm_pkg::ctrl_cmd_t  cmd
);
	import swrm_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EXEC = 5'b00010,
		ST_READ = 5'b00100,
		ST_LOAD = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_ready    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = stat.need_read ? ST_READ : ST_EMIT;
			end
			// new top addresses go to the memories
			ST_READ: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load_rd = 1'b1;
				state_d     = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

// ===== hw/rtl/swrm_dp.sv =====
`timescale 1ns / 1ps

module swrm_dp #(
	parameter int DEPTH = swrm_pkg::DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  swrm_pkg::ctrl_cmd_t             cmd,
	output swrm_pkg::dp_stat_t              stat,
	input  logic                            in_command,
	input  logic [swrm_pkg::VAL_W-1:0]      in_value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [swrm_pkg::VAL_W-1:0]      out_top,
	output logic [swrm_pkg::VAL_W-1:0]      out_min,
	output logic [swrm_pkg::CNT_OUT_W-1:0]  out_count,
	output logic                            out_empty,
	output logic [swrm_pkg::STATUS_W-1:0]   out_status
);
	import swrm_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic             cmd_q;
	logic [VAL_W-1:0] val_q;
	logic [CW-1:0]    count_q, mcount_q;
	logic [VAL_W-1:0] top_q, min_q;
	status_t          status_q;

	logic             out_valid_q;
	logic [VAL_W-1:0] out_top_q, out_min_q;
	logic [CNT_OUT_W-1:0] out_count_q;
	logic             out_empty_q;
	logic [STATUS_W-1:0] out_status_q;

	logic             is_full, min_push;
	logic             v_we, m_we;
	logic [CW-1:0]    count_m1, mcount_m1;
	logic [VAL_W-1:0] v_rdata, m_rdata;

	// decode of the held command
	assign is_full  = (count_q == CW'(DEPTH));
	assign min_push = (mcount_q == '0) ||
		((mcount_q < CW'(DEPTH)) && ($signed(val_q) <= $signed(min_q)));
	assign v_we      = cmd.exec && (cmd_q == CMD_PUSH) && !is_full;
	assign m_we      = v_we && min_push;
	assign count_m1  = count_q - CW'(1);
	assign mcount_m1 = mcount_q - CW'(1);

	assign stat.need_read = (cmd_q == CMD_POP) && (count_q > CW'(1));
	assign stat.out_free  = !out_valid_q || out_ready;

	swrm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_value_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (count_q[AW-1:0]),
		.wdata (val_q),
		.raddr (count_m1[AW-1:0]),
		.rdata (v_rdata)
	);

	swrm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_min_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (mcount_q[AW-1:0]),
		.wdata (val_q),
		.raddr (mcount_m1[AW-1:0]),
		.rdata (m_rdata)
	);

	// input item capture
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q <= in_command;
			val_q <= in_value;
		end
	end

	// stack counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			mcount_q <= '0;
		end else if (cmd.exec) begin
			if (cmd_q == CMD_PUSH) begin
				if (!is_full) begin
					count_q <= count_q + CW'(1);
					if (min_push) begin
						mcount_q <= mcount_q + CW'(1);
					end
				end
			end else if (count_q != '0) begin
				count_q <= count_m1;
				if ((mcount_q != '0) && (top_q == min_q)) begin
					mcount_q <= mcount_m1;
				end
			end
		end
	end

	// cached tops of both stacks and status
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			if (cmd_q == CMD_PUSH) begin
				status_q <= is_full ? STATUS_PUSH_FULL : STATUS_OK;
				if (!is_full) begin
					top_q <= val_q;
					if (min_push) begin
						min_q <= val_q;
					end
				end
			end else begin
				status_q <= (count_q == '0) ? STATUS_POP_EMPTY : STATUS_OK;
			end
		end
		if (cmd.load_rd) begin
			top_q <= v_rdata;
			min_q <= m_rdata;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_top_q    <= (count_q != '0) ? top_q : '0;
			out_min_q    <= ((count_q != '0) && (mcount_q != '0)) ? min_q : '0;
			out_count_q  <= CNT_OUT_W'(count_q);
			out_empty_q  <= (count_q == '0);
			out_status_q <= status_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_top    = out_top_q;
	assign out_min    = out_min_q;
	assign out_count  = out_count_q;
	assign out_empty  = out_empty_q;
	assign out_status = out_status_q;
endmodule

// ===== hw/rtl/stack_with_running_minimum_core.sv =====
// sequence: a push, a rejected command or a pop that empties the stack passes EXEC and EMIT,
//   a pop that leaves values behind passes EXEC, READ, LOAD and EMIT (memory read)
// commands are taken only in IDLE, after the last emit; EMIT stalls on a full output register
// the next item is taken while the previous result waits in the output register
// reset: asynchronous, clears the counts so the stack is empty; stores are not cleared
`timescale 1ns / 1ps

module stack_with_running_minimum_core #(
	parameter int DEPTH = swrm_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	swrm_in_if.sink     cmd,
	swrm_out_if.source  result
);
	import swrm_pkg::*;

	ctrl_cmd_t ctl;
	dp_stat_t  stat;

	// sequencer
	swrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (cmd.ready),
		.stat     (stat),
		.cmd      (ctl)
	);

	// stores, counts and output register
	swrm_dp #(.DEPTH(DEPTH)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (ctl),
		.stat       (stat),
		.in_command (cmd.command),
		.in_value   (cmd.push_value),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.out_top    (result.top_value),
		.out_min    (result.min_value),
		.out_count  (result.item_count),
		.out_empty  (result.is_empty),
		.out_status (result.status)
	);
endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import swrm_pkg::*;

	localparam int STACK_DEPTH    = DEPTH_DEF;
	localparam int HOLD_CYCLES    = 300;
	localparam int QUIET_LIMIT    = 3000;
	localparam int SETTLE_CYCLES  = 12;
	localparam int REPORT_LIMIT   = 10;

	// one result as the block reports it
	typedef struct {
		logic signed [VAL_W-1:0] top;
		logic signed [VAL_W-1:0] min;
		logic [CNT_OUT_W-1:0]    count;
		logic                    empty;
		logic [STATUS_W-1:0]     status;
	} stack_result_t;

	// running-minimum stack predictor plus queue of expected results
	class min_stack_scoreboard;
		logic signed [VAL_W-1:0] values[STACK_DEPTH];
		logic signed [VAL_W-1:0] minima[STACK_DEPTH];
		int unsigned value_cnt;
		int unsigned minima_cnt;
		stack_result_t expected_q[$];
		int unsigned mismatches;
		int unsigned checked;
		int unsigned pushes;
		int unsigned pops;
		int unsigned empty_pops;
		int unsigned full_pushes;
		int unsigned peak_depth;

		function void note_command(logic command, logic signed [VAL_W-1:0] value);
			stack_result_t exp_r;
			status_t st;
			logic signed [VAL_W-1:0] popped;
			st = STATUS_OK;
			if (command == CMD_PUSH) begin
				pushes++;
				if (value_cnt >= STACK_DEPTH) begin
					st = STATUS_PUSH_FULL;
					full_pushes++;
				end else begin
					values[value_cnt] = value;
					value_cnt++;
					// new minimum, or a repeat of the current one
					if (minima_cnt == 0) begin
						minima[0] = value;
						minima_cnt = 1;
					end else if (minima_cnt < STACK_DEPTH && value <= minima[minima_cnt-1]) begin
						minima[minima_cnt] = value;
						minima_cnt++;
					end
				end
			end else begin
				pops++;
				if (value_cnt == 0) begin
					st = STATUS_POP_EMPTY;
					empty_pops++;
				end else begin
					popped = values[value_cnt-1];
					value_cnt--;
					if (minima_cnt > 0 && popped === minima[minima_cnt-1])
						minima_cnt--;
				end
			end
			if (value_cnt > peak_depth)
				peak_depth = value_cnt;
			// state after the command
			exp_r.top    = (value_cnt > 0) ? values[value_cnt-1] : '0;
			exp_r.min    = (value_cnt > 0 && minima_cnt > 0) ? minima[minima_cnt-1] : '0;
			exp_r.count  = value_cnt[CNT_OUT_W-1:0];
			exp_r.empty  = (value_cnt == 0);
			exp_r.status = st;
			expected_q.insert(expected_q.size(), exp_r);
		endfunction

		function void check_result(stack_result_t got);
			stack_result_t exp_r;
			checked++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("[%0t] unexpected result: top=%0d min=%0d count=%0d empty=%0b status=%0d",
						$realtime, got.top, got.min, got.count, got.empty, got.status);
				return;
			end
			exp_r = expected_q.pop_front();
			if (got.top !== exp_r.top || got.min !== exp_r.min || got.count !== exp_r.count ||
					got.empty !== exp_r.empty || got.status !== exp_r.status) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("[%0t] result %0d mismatch", $realtime, checked);
					$display("  expected: top=%0d min=%0d count=%0d empty=%0b status=%0d",
						exp_r.top, exp_r.min, exp_r.count, exp_r.empty, exp_r.status);
					$display("  actual:   top=%0d min=%0d count=%0d empty=%0b status=%0d",
						got.top, got.min, got.count, got.empty, got.status);
				end
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	swrm_in_if  cmd_if ();
	swrm_out_if res_if ();

	stack_with_running_minimum_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.result (res_if)
	);

	min_stack_scoreboard sb = new;

	int unsigned src_idle_pct = 0;
	int unsigned snk_idle_pct = 0;
	int unsigned hold_requests = 0;
	int unsigned hold_served = 0;
	int unsigned hold_left = 0;

	// clock
	always #10 clk = ~clk;

	// note every accepted command
	always @(posedge clk) begin
		if (arst_n && cmd_if.valid && cmd_if.ready)
			sb.note_command(cmd_if.command, cmd_if.push_value);
	end

	// check every accepted result
	always @(posedge clk) begin
		stack_result_t got;
		if (arst_n && res_if.valid && res_if.ready) begin
			got.top    = res_if.top_value;
			got.min    = res_if.min_value;
			got.count  = res_if.item_count;
			got.empty  = res_if.is_empty;
			got.status = res_if.status;
			sb.check_result(got);
		end
	end

	// result receiver with random stalls and an occasional long hold-off
	initial begin
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else if (hold_served != hold_requests) begin
				hold_served++;
				hold_left = HOLD_CYCLES;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	// watchdog on cycles with no item moving on either side
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout after %0d quiet cycles, %0d results outstanding", quiet, sb.pending());
		$display("stack_with_running_minimum_core regression: fail");
		$finish;
	end

	// offer one command, with a random gap before it
	task automatic send_command(input logic command, input logic signed [VAL_W-1:0] value);
		while ($urandom_range(99) < src_idle_pct) begin
			cmd_if.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_if.valid      <= 1'b1;
		cmd_if.command    <= command;
		cmd_if.push_value <= value;
		@(posedge clk);
		while (!cmd_if.ready)
			@(posedge clk);
	endtask

	// stop offering until every expected result is back
	task automatic wait_drained();
		cmd_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// value mix: full range, a narrow band for repeats, extremes, large negatives
	function automatic logic signed [VAL_W-1:0] draw_value();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 35)
			return $urandom();
		else if (pick < 75)
			return int'($urandom_range(40)) - 20;
		else if (pick < 88) begin
			case ($urandom_range(3))
				0: return 32'sh7fffffff;
				1: return 32'sh80000000;
				2: return 32'sh00000000;
				default: return 32'shffffffff;
			endcase
		end else
			return -int'($urandom_range(2000000));
	endfunction

	// bursts that lean toward pushes or pops, so the stack fills and drains
	task automatic run_random(input int unsigned count);
		int unsigned done_n;
		int unsigned burst;
		int unsigned push_pct;
		int unsigned k;
		done_n = 0;
		while (done_n < count) begin
			case ($urandom_range(3))
				0: push_pct = 85;
				1: push_pct = 50;
				2: push_pct = 15;
				default: push_pct = 100;
			endcase
			burst = $urandom_range(20, 80);
			for (k = 0; k < burst && done_n < count; k++) begin
				send_command(($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP, draw_value());
				done_n++;
			end
		end
	endtask

	// main sequence
	initial begin
		arst_n            <= 1'b0;
		cmd_if.valid      <= 1'b0;
		cmd_if.command    <= CMD_PUSH;
		cmd_if.push_value <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pop, extremes, repeated minimum, ignored push value
		src_idle_pct = 18;
		snk_idle_pct = 65;
		send_command(CMD_POP, 32'sh12345678);
		send_command(CMD_PUSH, 32'sh7fffffff);
		send_command(CMD_PUSH, 32'sh80000000);
		send_command(CMD_PUSH, 32'sh80000000);
		send_command(CMD_PUSH, 32'sh00000000);
		send_command(CMD_PUSH, 32'shffffffff);
		send_command(CMD_POP, 32'sh00000000);
		send_command(CMD_POP, 32'sh00000000);
		send_command(CMD_POP, 32'sh00000000);
		send_command(CMD_POP, 32'sh00000000);
		send_command(CMD_POP, 32'sh00000000);
		send_command(CMD_POP, 32'shffffffff);
		send_command(CMD_PUSH, 32'sh00000005);
		send_command(CMD_PUSH, 32'sh00000005);
		send_command(CMD_PUSH, 32'sh00000007);
		send_command(CMD_PUSH, 32'sh80000001);
		send_command(CMD_PUSH, 32'sh00000003);
		send_command(CMD_POP, 32'sh00000000);
		send_command(CMD_POP, 32'sh00000000);
		send_command(CMD_POP, 32'sh00000000);
		send_command(CMD_POP, 32'sh00000000);
		send_command(CMD_POP, 32'sh00000000);
		send_command(CMD_POP, 32'sh00000000);

		// random, sender mostly busy, receiver mostly stalled
		run_random(460);
		wait_drained();

		// random, roles swapped
		src_idle_pct = 65;
		snk_idle_pct = 18;
		run_random(460);
		wait_drained();

		// random, no idling, starting under a long receiver hold-off
		src_idle_pct = 0;
		snk_idle_pct = 0;
		hold_requests++;
		run_random(480);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d pushes (%0d on a full stack) and %0d pops (%0d on an empty stack)",
			sb.pushes, sb.full_pushes, sb.pops, sb.empty_pops);
		$display("checked %0d results, peak depth %0d of %0d, %0d mismatches",
			sb.checked, sb.peak_depth, STACK_DEPTH, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("stack_with_running_minimum_core regression: pass");
		else
			$display("stack_with_running_minimum_core regression: fail");
		$finish;
	end

endmodule
